// ===== src/pmu_pkg.sv =====
package pmu_pkg;

	// Field widths of the request and result ports
	localparam int COEFF_IN_W  = 24;
	localparam int POWER_IN_W  = 4;
	localparam int POWER_OUT_W = 5;
	localparam int STORE_W     = 32;
	localparam int ACC_W       = 64;

	// Default highest stored power
	localparam int MAX_POWER_DEF = 15;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // add the request's term into its store
		logic mac;    // one multiply of the current pair
		logic scan;   // read and clear one product entry
		logic flush;  // emit the held term or the empty marker
	} pmu_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic mac_last;   // current pair is the last one
		logic scan_last;  // current product entry is power zero
	} pmu_stat_t;

endpackage

// ===== src/pmu_ctrl.sv =====
module pmu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              req_type,
	input  logic              final_term,
	input  pmu_pkg::pmu_stat_t stat,
	output pmu_pkg::pmu_cmd_t  cmd,
	output logic              busy
);
	import pmu_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MAC   = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && req_type && final_term) state_d = ST_MAC;
			ST_MAC:   if (stat.mac_last) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_SCAN;
			ST_SCAN:  if (stat.scan_last) state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Drive datapath commands
	always_comb begin
		cmd       = '0;
		cmd.load  = accept;
		cmd.mac   = (state_q == ST_MAC);
		cmd.scan  = (state_q == ST_SCAN);
		cmd.flush = (state_q == ST_FLUSH);
	end

`ifndef SYNTHESIS
	a_mac_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) && stat.mac_last |=> (state_q == ST_DRAIN))
		else $error("multiply pass did not end after the last pair");
	a_flush_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |=> (state_q == ST_IDLE))
		else $error("flush lasted more than one cycle");
	a_busy_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.load)
		else $error("request loaded while busy");
`endif

endmodule

// ===== src/pmu_datapath.sv =====
module pmu_datapath #(
	parameter int MAX_POWER = pmu_pkg::MAX_POWER_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pmu_pkg::pmu_cmd_t                     cmd,
	output pmu_pkg::pmu_stat_t                    stat,
	input  logic                                  req_type,
	input  logic signed [pmu_pkg::COEFF_IN_W-1:0] coeff_in,
	input  logic [pmu_pkg::POWER_IN_W-1:0]        power_in,
	output logic                                  result_valid,
	output logic signed [pmu_pkg::ACC_W-1:0]      coeff_out,
	output logic [pmu_pkg::POWER_OUT_W-1:0]       power_out,
	output logic                                  last_out,
	output logic                                  empty_out
);
	import pmu_pkg::*;

	localparam int IN_DEPTH   = MAX_POWER + 1;
	localparam int PROD_DEPTH = 2 * MAX_POWER + 1;
	localparam int IW         = $clog2(IN_DEPTH);
	localparam int PW         = $clog2(PROD_DEPTH);
	localparam logic [IW-1:0] IDX_LAST = IW'(IN_DEPTH - 1);
	localparam logic [PW-1:0] PIDX_TOP = PW'(PROD_DEPTH - 1);

	logic signed [STORE_W-1:0] first_q  [IN_DEPTH];
	logic signed [STORE_W-1:0] second_q [IN_DEPTH];
	logic signed [ACC_W-1:0]   prod_q   [PROD_DEPTH];

	logic [IW-1:0] i_q, j_q;
	logic [PW-1:0] k_q;

	logic                    ld_ok;
	logic [IW-1:0]           ld_idx;
	logic signed [STORE_W-1:0] ld_add;
	logic signed [ACC_W-1:0] mul;
	logic signed [ACC_W-1:0] mul_s1;
	logic [PW-1:0]           idx_s1;
	logic                    v_s1;
	logic signed [ACC_W-1:0] cur;
	logic                    cur_nz;
	logic signed [ACC_W-1:0] pend_q;
	logic [PW-1:0]           pend_k_q;
	logic                    pend_v_q;

	assign ld_ok  = (32'(power_in) <= MAX_POWER);
	assign ld_idx = IW'(power_in);
	assign ld_add = STORE_W'(coeff_in);

	assign stat.mac_last  = (i_q == IDX_LAST) && (j_q == IDX_LAST);
	assign stat.scan_last = (k_q == '0);

	// Add loaded terms, clear input stores as each row and column is used up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < IN_DEPTH; n++) begin
				first_q[n]  <= '0;
				second_q[n] <= '0;
			end
		end else if (cmd.load) begin
			if (ld_ok && !req_type) first_q[ld_idx] <= first_q[ld_idx] + ld_add;
			if (ld_ok && req_type) second_q[ld_idx] <= second_q[ld_idx] + ld_add;
		end else if (cmd.mac) begin
			if (j_q == IDX_LAST) first_q[i_q] <= '0;
			if (i_q == IDX_LAST) second_q[j_q] <= '0;
		end
	end

	// Advance pair and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= PIDX_TOP;
		end else begin
			if (cmd.mac) begin
				if (j_q == IDX_LAST) begin
					j_q <= '0;
					i_q <= (i_q == IDX_LAST) ? '0 : i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (cmd.scan) begin
				k_q <= (k_q == '0) ? PIDX_TOP : k_q - 1'b1;
			end
		end
	end

	// Multiply stage
	assign mul = ACC_W'(first_q[i_q]) * ACC_W'(second_q[j_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.mac;
		end
	end

	always_ff @(posedge clk) begin
		mul_s1 <= mul;
		idx_s1 <= PW'(i_q) + PW'(j_q);
	end

	// Accumulate products, clear each entry as the scan reads it
	assign cur    = prod_q[k_q];
	assign cur_nz = (cur != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < PROD_DEPTH; n++) begin
				prod_q[n] <= '0;
			end
		end else if (v_s1) begin
			prod_q[idx_s1] <= prod_q[idx_s1] + mul_s1;
		end else if (cmd.scan) begin
			prod_q[k_q] <= '0;
		end
	end

	// Hold one nonzero term back so the last one can be marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (cmd.scan && cur_nz) begin
			pend_v_q <= 1'b1;
		end else if (cmd.flush) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && cur_nz) begin
			pend_q   <= cur;
			pend_k_q <= k_q;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= (cmd.scan && cur_nz && pend_v_q) || cmd.flush;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush && !pend_v_q) begin
			coeff_out <= '0;
			power_out <= '0;
			last_out  <= 1'b1;
			empty_out <= 1'b1;
		end else begin
			coeff_out <= pend_q;
			power_out <= POWER_OUT_W'(pend_k_q);
			last_out  <= cmd.flush;
			empty_out <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(cmd.scan) || $past(cmd.flush))
		else $error("result outside scan or flush");
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && empty_out |-> last_out && (coeff_out == '0))
		else $error("malformed empty result");
	a_term_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !empty_out |-> (coeff_out != '0))
		else $error("zero term emitted");
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !v_s1 && !pend_v_q)
		else $error("request loaded during a product");
`endif

endmodule

// ===== src/polynomial_multiplier_unit.sv =====
// Sparse polynomial multiplier. Each request carries one term (coefficient and
// power) of the first (req_type 0) or second (req_type 1) polynomial; terms of
// equal power add up. A second-polynomial request with final_term set starts the
// product: a single 32x32 multiplier walks all (MAX_POWER+1)^2 pairs one per
// cycle, then the product store is scanned from the top power down, one entry per
// cycle, while busy stays high. Nonzero terms come out in descending power,
// each on the result ports for one cycle with result_valid high; the last carries
// last_out. An all-zero product gives one result with empty_out and last_out set.
// There is no backpressure: the receiver must take every result in the cycle it
// appears.
module polynomial_multiplier_unit #(
	parameter int MAX_POWER = pmu_pkg::MAX_POWER_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  req_type,
	input  logic signed [pmu_pkg::COEFF_IN_W-1:0] coeff_in,
	input  logic [pmu_pkg::POWER_IN_W-1:0]        power_in,
	input  logic                                  final_term,
	output logic                                  result_valid,
	output logic signed [pmu_pkg::ACC_W-1:0]      coeff_out,
	output logic [pmu_pkg::POWER_OUT_W-1:0]       power_out,
	output logic                                  last_out,
	output logic                                  empty_out
);
	import pmu_pkg::*;

	pmu_cmd_t  cmd;
	pmu_stat_t stat;

	pmu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.final_term (final_term),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy)
	);

	pmu_datapath #(
		.MAX_POWER (MAX_POWER)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req_type),
		.coeff_in     (coeff_in),
		.power_in     (power_in),
		.result_valid (result_valid),
		.coeff_out    (coeff_out),
		.power_out    (power_out),
		.last_out     (last_out),
		.empty_out    (empty_out)
	);

endmodule
